// ===== hdl/rotation_matrix_to_quaternion_unit_defines.svh =====
// Assertion helpers shared by the checker.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rmq check failed");

// Next-cycle implication, held off during reset.
`define RMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rmq check failed");

`endif

// ===== hdl/rmq_pkg.sv =====
package rmq_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 30;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_M11   = 2'd1,
        BR_M22   = 2'd2,
        BR_M33   = 2'd3
    } t_branch;

endpackage

// ===== hdl/rmq_front.sv =====
module rmq_front #(
    parameter int W = rmq_pkg::WORD_BITS,
    parameter int F = rmq_pkg::FRAC_BITS,
    localparam int RW  = W + 2,
    localparam int NMW = W + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_ce,
    input  logic                    i_vld,
    input  logic signed [W-1:0]     i_m [9],
    output logic                    o_vld,
    output rmq_pkg::t_branch        o_br,
    output logic                    o_degen,
    output logic [RW-1:0]           o_rmag,
    output logic [2:0]              o_sgn,
    output logic [2:0][NMW-1:0]     o_mag
);

    localparam logic signed [W+2:0] ONE = (W+3)'(1) << F;

    logic signed [W+1:0]   tr;
    logic signed [W+2:0]   x11, x22, x33;
    logic signed [W:0]     d32_23, d13_31, d21_12, s12_21, s13_31, s23_32;
    rmq_pkg::t_branch      n_br;
    logic signed [W+2:0]   n_r;
    logic signed [W:0]     n_num [3];

    rmq_pkg::t_branch      r_br;
    logic signed [W+2:0]   r_r;
    logic signed [W:0]     r_num [3];
    logic                  r_vld1;

    // stage 1: pick the branch, form radicand and off-diagonal terms
    always_comb begin
        tr  = (W+2)'(i_m[0]) + (W+2)'(i_m[4]) + (W+2)'(i_m[8]);
        x11 = (W+3)'(i_m[0]);
        x22 = (W+3)'(i_m[4]);
        x33 = (W+3)'(i_m[8]);
        d32_23 = (W+1)'(i_m[7]) - (W+1)'(i_m[5]);
        d13_31 = (W+1)'(i_m[2]) - (W+1)'(i_m[6]);
        d21_12 = (W+1)'(i_m[3]) - (W+1)'(i_m[1]);
        s12_21 = (W+1)'(i_m[1]) + (W+1)'(i_m[3]);
        s13_31 = (W+1)'(i_m[2]) + (W+1)'(i_m[6]);
        s23_32 = (W+1)'(i_m[5]) + (W+1)'(i_m[7]);
        if (tr > 0) begin
            n_br     = rmq_pkg::BR_TRACE;
            n_r      = ONE + (W+3)'(tr);
            n_num[0] = d32_23;
            n_num[1] = d13_31;
            n_num[2] = d21_12;
        end else if (i_m[0] > i_m[4] && i_m[0] > i_m[8]) begin
            n_br     = rmq_pkg::BR_M11;
            n_r      = ONE + x11 - x22 - x33;
            n_num[0] = d32_23;
            n_num[1] = s12_21;
            n_num[2] = s13_31;
        end else if (i_m[4] > i_m[8]) begin
            n_br     = rmq_pkg::BR_M22;
            n_r      = ONE + x22 - x11 - x33;
            n_num[0] = d13_31;
            n_num[1] = s12_21;
            n_num[2] = s23_32;
        end else begin
            n_br     = rmq_pkg::BR_M33;
            n_r      = ONE + x33 - x11 - x22;
            n_num[0] = d21_12;
            n_num[1] = s13_31;
            n_num[2] = s23_32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_ce) begin
            r_vld1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_br  <= n_br;
            r_r   <= n_r;
            r_num <= n_num;
        end
    end

    // stage 2: split signs and magnitudes, flag a non-positive radicand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_ce) begin
            o_vld <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_br    <= r_br;
            o_degen <= (r_r <= 0);
            o_rmag  <= r_r[RW-1:0];
            for (int l = 0; l < 3; l++) begin
                o_sgn[l] <= r_num[l][W];
                o_mag[l] <= r_num[l][W] ? NMW'(-r_num[l]) : NMW'(r_num[l]);
            end
        end
    end

endmodule

// ===== hdl/rmq_sqrt.sv =====
module rmq_sqrt #(
    parameter int RW = rmq_pkg::WORD_BITS + 2,
    parameter int F  = rmq_pkg::FRAC_BITS,
    parameter int SW = 1,
    localparam int SQW = RW + F,
    localparam int SQE = SQW + (SQW % 2),
    localparam int RTW = SQE / 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ce,
    input  logic            i_vld,
    input  logic [RW-1:0]   i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [RTW-1:0]  o_root,
    output logic [SW-1:0]   o_side
);

    logic [RTW+1:0] r_rem  [RTW];
    logic [RTW-1:0] r_root [RTW];
    logic [SQE-1:0] r_v    [RTW];
    logic [SW-1:0]  r_side [RTW];
    logic [RTW-1:0] r_vld;

    // one root bit per stage
    for (genvar g = 0; g < RTW; g++) begin : g_stage
        logic [RTW+1:0] p_rem;
        logic [RTW-1:0] p_root;
        logic [SQE-1:0] p_v;
        logic [SW-1:0]  p_side;
        logic           p_vld;
        logic [RTW+3:0] tmp;
        logic [RTW+3:0] trial;
        logic           ge;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_v    = SQE'({i_rad, {F{1'b0}}});
            assign p_side = i_side;
            assign p_vld  = i_vld;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_v    = r_v[g-1];
            assign p_side = r_side[g-1];
            assign p_vld  = r_vld[g-1];
        end

        always_comb begin
            tmp   = {p_rem, p_v[SQE-1 -: 2]};
            trial = {2'b00, p_root, 2'b01};
            ge    = (tmp >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ce) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g]  <= ge ? (RTW+2)'(tmp - trial) : (RTW+2)'(tmp);
                r_root[g] <= {p_root[RTW-2:0], ge};
                r_v[g]    <= {p_v[SQE-3:0], 2'b00};
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[RTW-1];
    assign o_root = r_root[RTW-1];
    assign o_side = r_side[RTW-1];

endmodule

// ===== hdl/rmq_div.sv =====
module rmq_div #(
    parameter int NMW = rmq_pkg::WORD_BITS + 1,
    parameter int F   = rmq_pkg::FRAC_BITS,
    parameter int DW  = 33,
    parameter int SW  = 1,
    localparam int QW = NMW + F
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_vld,
    input  logic [2:0][NMW-1:0] i_mag,
    input  logic [DW-1:0]       i_d,
    input  logic [SW-1:0]       i_side,
    output logic                o_vld,
    output logic [2:0][QW-1:0]  o_q,
    output logic [DW-1:0]       o_d,
    output logic [SW-1:0]       o_side
);

    logic [2:0][DW-1:0] r_rem  [QW];
    logic [2:0][QW-1:0] r_n    [QW];
    logic [2:0][QW-1:0] r_q    [QW];
    logic [DW-1:0]      r_d    [QW];
    logic [SW-1:0]      r_side [QW];
    logic [QW-1:0]      r_vld;

    // one quotient bit per stage, three lanes side by side
    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [2:0][DW-1:0] p_rem;
        logic [2:0][QW-1:0] p_n;
        logic [2:0][QW-1:0] p_q;
        logic [DW-1:0]      p_d;
        logic [SW-1:0]      p_side;
        logic               p_vld;
        logic [2:0][DW:0]   tmp;
        logic [2:0]         ge;

        if (g == 0) begin : g_first
            assign p_rem = '0;
            assign p_q   = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign p_n[l] = {i_mag[l], {F{1'b0}}};
            end
            assign p_d    = i_d;
            assign p_side = i_side;
            assign p_vld  = i_vld;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_n    = r_n[g-1];
            assign p_q    = r_q[g-1];
            assign p_d    = r_d[g-1];
            assign p_side = r_side[g-1];
            assign p_vld  = r_vld[g-1];
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                tmp[l] = {p_rem[l], p_n[l][QW-1]};
                ge[l]  = (tmp[l] >= {1'b0, p_d});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ce) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[g][l] <= ge[l] ? DW'(tmp[l] - {1'b0, p_d}) : DW'(tmp[l]);
                    r_n[g][l]   <= {p_n[l][QW-2:0], 1'b0};
                    r_q[g][l]   <= {p_q[l][QW-2:0], ge[l]};
                end
                r_d[g]    <= p_d;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_q    = r_q[QW-1];
    assign o_d    = r_d[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// ===== hdl/rmq_out.sv =====
module rmq_out #(
    parameter int W  = rmq_pkg::WORD_BITS,
    parameter int QW = 63,
    parameter int DW = 33
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_vld,
    input  logic [2:0][QW-1:0]  i_q,
    input  logic [DW-1:0]       i_d,
    input  rmq_pkg::t_branch    i_br,
    input  logic                i_degen,
    input  logic [2:0]          i_sgn,
    output logic                o_vld,
    output logic [3:0][W-1:0]   o_quat,
    output rmq_pkg::t_branch    o_br,
    output logic                o_degen
);

    localparam logic [QW-1:0] MAXP   = QW'({1'b0, {(W-1){1'b1}}});
    localparam logic [QW-1:0] MINMAG = MAXP + QW'(1);

    function automatic logic [W-1:0] f_sat(input logic [QW-1:0] q, input logic neg);
        logic [W-1:0] res;
        if (neg) begin
            if (q > MINMAG) begin
                res = {1'b1, {(W-1){1'b0}}};
            end else begin
                res = W'(-q);
            end
        end else begin
            if (q > MAXP) begin
                res = MAXP[W-1:0];
            end else begin
                res = q[W-1:0];
            end
        end
        return res;
    endfunction

    logic               dg;
    logic [3:0][W-1:0]  n_quat;

    // lanes hold the non-leading components in ascending order
    always_comb begin
        dg = i_degen | (i_d == '0);
        for (int k = 0; k < 4; k++) begin
            if (k == int'(i_br)) begin
                n_quat[k] = f_sat(QW'(i_d[DW-1:2]), 1'b0);
            end else if (k < int'(i_br)) begin
                n_quat[k] = f_sat(i_q[k], i_sgn[k]);
            end else begin
                n_quat[k] = f_sat(i_q[k-1], i_sgn[k-1]);
            end
            if (dg) begin
                n_quat[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_ce) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_quat  <= n_quat;
            o_br    <= i_br;
            o_degen <= dg;
        end
    end

endmodule

// ===== hdl/rotation_matrix_to_quaternion_unit.sv =====
// Rotation matrix to unit quaternion (Shepperd's method) in signed fixed
// point. Each transfer on the slave side carries one 3x3 matrix; the master
// side returns w, x, y, z plus the branch used and a degenerate flag. The
// unit is a fully pipelined datapath: a new matrix is taken every cycle in
// which the pipe advances. Data runs through the front, then RTW =
// ceil((WORD_BITS+2+FRAC_BITS)/2) square-root stages (one root bit each),
// then QW = WORD_BITS+1+FRAC_BITS divider stages (one quotient bit each,
// three lanes), then the output register. The default format is Q2.30.
// The whole pipe advances together; it holds only while a result sits in
// the output register and the master side does not take it.
module rotation_matrix_to_quaternion_unit #(
    parameter int WORD_BITS = rmq_pkg::WORD_BITS,
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS,
    localparam int IW = ((9 * WORD_BITS + 7) / 8) * 8,
    localparam int OW = ((4 * WORD_BITS + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // m11, m12, m13, m21, m22, m23, m31, m32, m33 (lowest first), zero pad
    input  logic [IW-1:0] i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // quat_w, quat_x, quat_y, quat_z (lowest first), zero pad
    output logic [OW-1:0] o_m_tdata,
    // branch_case [1:0], degenerate [2]
    output logic [2:0]    o_m_tuser
);

    localparam int W    = WORD_BITS;
    localparam int RW   = W + 2;
    localparam int NMW  = W + 1;
    localparam int SQW  = RW + FRAC_BITS;
    localparam int RTW  = (SQW + (SQW % 2)) / 2;
    localparam int DW   = RTW + 1;
    localparam int QW   = NMW + FRAC_BITS;
    localparam int SSW  = 6 + 3 * NMW;

    logic                   ce;
    logic signed [W-1:0]    mat [9];

    logic                   f_vld;
    rmq_pkg::t_branch       f_br;
    logic                   f_degen;
    logic [RW-1:0]          f_rmag;
    logic [2:0]             f_sgn;
    logic [2:0][NMW-1:0]    f_mag;

    logic [SSW-1:0]         s_side_in;
    logic                   s_vld;
    logic [RTW-1:0]         s_root;
    logic [SSW-1:0]         s_side;

    logic                   d_vld;
    logic [2:0][QW-1:0]     d_q;
    logic [DW-1:0]          d_d;
    logic [5:0]             d_side;

    logic [3:0][W-1:0]      quat;
    rmq_pkg::t_branch       o_br;
    logic                   o_degen;

    // advance everything unless a finished result is held at the output
    assign ce         = ~o_m_tvalid | i_m_tready;
    assign o_s_tready = ce;

    for (genvar k = 0; k < 9; k++) begin : g_unpack
        assign mat[k] = i_s_tdata[k*W +: W];
    end

    rmq_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (i_s_tvalid),
        .i_m     (mat),
        .o_vld   (f_vld),
        .o_br    (f_br),
        .o_degen (f_degen),
        .o_rmag  (f_rmag),
        .o_sgn   (f_sgn),
        .o_mag   (f_mag)
    );

    // carry branch, flag and numerators alongside the root
    assign s_side_in = {f_br, f_degen, f_sgn, f_mag};

    rmq_sqrt #(
        .RW (RW),
        .F  (FRAC_BITS),
        .SW (SSW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (f_vld),
        .i_rad   (f_rmag),
        .i_side  (s_side_in),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    rmq_div #(
        .NMW (NMW),
        .F   (FRAC_BITS),
        .DW  (DW),
        .SW  (6)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (s_vld),
        .i_mag   (s_side[3*NMW-1:0]),
        .i_d     ({s_root, 1'b0}),
        .i_side  (s_side[SSW-1 -: 6]),
        .o_vld   (d_vld),
        .o_q     (d_q),
        .o_d     (d_d),
        .o_side  (d_side)
    );

    rmq_out #(
        .W  (W),
        .QW (QW),
        .DW (DW)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (d_vld),
        .i_q     (d_q),
        .i_d     (d_d),
        .i_br    (rmq_pkg::t_branch'(d_side[5:4])),
        .i_degen (d_side[3]),
        .i_sgn   (d_side[2:0]),
        .o_vld   (o_m_tvalid),
        .o_quat  (quat),
        .o_br    (o_br),
        .o_degen (o_degen)
    );

    assign o_m_tdata = OW'(quat);
    assign o_m_tuser = {o_degen, o_br};

endmodule

// ===== hdl/rmq_checker.sv =====
`include "rotation_matrix_to_quaternion_unit_defines.svh"

module rmq_checker #(
    parameter int OW = ((4 * rmq_pkg::WORD_BITS + 7) / 8) * 8
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_s_tready,
    input logic          o_m_tvalid,
    input logic          i_m_tready,
    input logic [OW-1:0] o_m_tdata,
    input logic [2:0]    o_m_tuser
);

    // a stalled result holds its payload
    `RMQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // with no result waiting the input side is open
    `RMQ_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

    // a degenerate result carries an all-zero quaternion
    `RMQ_ASSERT_IMP(a_degen, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[2], o_m_tdata == '0)

    // ready follows the master side whenever a result is waiting
    `RMQ_ASSERT_IMP(a_stall, i_clk, i_rst_n, o_m_tvalid, o_s_tready == i_m_tready)

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(
    .OW (OW)
) u_rmq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== bench/tb_rotation_matrix_to_quaternion_unit.sv =====
module tb_rotation_matrix_to_quaternion_unit;

    localparam int W = rmq_pkg::WORD_BITS;
    localparam int F = rmq_pkg::FRAC_BITS;
    localparam int IW = ((9 * W + 7) / 8) * 8;
    localparam int OW = ((4 * W + 7) / 8) * 8;
    localparam int LATENCY = 2 + (W + 2 + F + 1) / 2 + (W + 1 + F) + 1;
    localparam int N_RANDOM = 1300;
    localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;
    localparam logic signed [W-1:0] ONE_Q = W'(64'd1 << F);
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic              degenerate;
        rmq_pkg::t_branch  branch;
        logic [W-1:0] qz;
        logic [W-1:0] qy;
        logic [W-1:0] qx;
        logic [W-1:0] qw;
    } t_quat;

    typedef logic signed [W-1:0] t_mat [9];

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    // m11 .. m33 (lowest first), zero pad
    logic [IW-1:0] i_s_tdata;
    logic          o_m_tvalid;
    logic          i_m_tready;
    // quat_w, quat_x, quat_y, quat_z (lowest first), zero pad
    logic [OW-1:0] o_m_tdata;
    // branch_case [1:0], degenerate [2]
    logic [2:0]    o_m_tuser;

    rotation_matrix_to_quaternion_unit dut (.*);

    // Quaternions still owed by the pipe, oldest first.
    t_quat pending_quats[$];
    int    errors;
    int    quats_seen;
    int    idle_cycles;
    int    branch_hits [4];
    int    degen_hits;
    bit    calm;        // no stalling on either side near the end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root, one bit per step, of a 128-bit radicand.
    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [127:0] rem;
        logic [127:0] trial;
        logic [63:0]  root;
        rem  = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = {rem[125:0], v[2*i+1], v[2*i]};
            trial = {root, 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[62:0], 1'b1};
            end else begin
                root = {root[62:0], 1'b0};
            end
        end
        return root;
    endfunction

    function automatic logic [W-1:0] saturate(logic [127:0] mag, bit neg);
        logic [127:0] lim;
        lim = 128'(MAXV);
        if (neg) begin
            if (mag > lim + 1) return MINV;
            return W'(-mag);
        end
        if (mag > lim) return MAXV;
        return W'(mag);
    endfunction

    // Shepperd conversion at the block's widths.
    function automatic t_quat quat_from_matrix(t_mat m);
        t_quat q;
        logic signed [71:0] trace, r;
        logic signed [71:0] num [4];
        logic [63:0]  root, d;
        logic [127:0] mag;
        rmq_pkg::t_branch br;
        trace = 72'(m[0]) + 72'(m[4]) + 72'(m[8]);
        num = '{default: '0};
        if (trace > 0) begin
            br = rmq_pkg::BR_TRACE; r = 72'(ONE_Q) + trace;
            num[1] = 72'(m[7]) - 72'(m[5]);
            num[2] = 72'(m[2]) - 72'(m[6]);
            num[3] = 72'(m[3]) - 72'(m[1]);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            br = rmq_pkg::BR_M11; r = 72'(ONE_Q) + 72'(m[0]) - 72'(m[4]) - 72'(m[8]);
            num[0] = 72'(m[7]) - 72'(m[5]);
            num[2] = 72'(m[1]) + 72'(m[3]);
            num[3] = 72'(m[2]) + 72'(m[6]);
        end else if (m[4] > m[8]) begin
            br = rmq_pkg::BR_M22; r = 72'(ONE_Q) + 72'(m[4]) - 72'(m[0]) - 72'(m[8]);
            num[0] = 72'(m[2]) - 72'(m[6]);
            num[1] = 72'(m[1]) + 72'(m[3]);
            num[3] = 72'(m[5]) + 72'(m[7]);
        end else begin
            br = rmq_pkg::BR_M33; r = 72'(ONE_Q) + 72'(m[8]) - 72'(m[0]) - 72'(m[4]);
            num[0] = 72'(m[3]) - 72'(m[1]);
            num[1] = 72'(m[2]) + 72'(m[6]);
            num[2] = 72'(m[5]) + 72'(m[7]);
        end
        q = '0;
        q.branch = br;
        root = (r > 0) ? isqrt(128'(r) << F) : '0;
        d = root << 1;
        if (r <= 0 || d == 0) begin
            q.degenerate = 1'b1;
            return q;
        end
        for (int k = 0; k < 4; k++) begin
            logic [W-1:0] c;
            if (k == int'(br)) begin
                c = saturate(128'(root >> 1), 1'b0);
            end else begin
                mag = 128'(num[k] < 0 ? -num[k] : num[k]);
                c = saturate((mag << F) / 128'(d), num[k] < 0);
            end
            case (k)
                0: q.qw = c;
                1: q.qx = c;
                2: q.qy = c;
                default: q.qz = c;
            endcase
        end
        return q;
    endfunction

    function automatic logic [IW-1:0] pack_matrix(t_mat m);
        logic [IW-1:0] v;
        v = '0;
        for (int i = 0; i < 9; i++) v[i*W +: W] = m[i];
        return v;
    endfunction

    // Check every transfer on the master side against the oldest quaternion.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_quat got;
            t_quat want;
            got = {o_m_tuser, o_m_tdata[4*W-1:0]};
            quats_seen++;
            if (pending_quats.size() == 0) begin
                $display("%0t: unexpected quaternion %h", $time, got);
                errors++;
            end else begin
                want = pending_quats.pop_front();
                if (got.qw !== want.qw || got.qx !== want.qx || got.qy !== want.qy
                        || got.qz !== want.qz || got.branch !== want.branch
                        || got.degenerate !== want.degenerate) begin
                    $display("%0t: mismatch expected w=%h x=%h y=%h z=%h br=%0d dg=%b",
                             $time, want.qw, want.qx, want.qy, want.qz,
                             want.branch, want.degenerate);
                    $display("%0t:          actual   w=%h x=%h y=%h z=%h br=%0d dg=%b",
                             $time, got.qw, got.qx, got.qy, got.qz,
                             got.branch, got.degenerate);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stall bursts, none during the calm tail.
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL rotation_matrix_to_quaternion_unit");
                $finish;
            end
        end
    end

    // Hand one matrix over and record its quaternion once taken.
    task automatic send_matrix(t_mat m);
        t_quat q;
        q = quat_from_matrix(m);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pack_matrix(m);
        do @(posedge i_clk); while (!o_s_tready);
        pending_quats.push_back(q);
        if (q.degenerate) degen_hits++;
        branch_hits[q.branch]++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge i_clk);
    endtask

    // Random matrix: mostly near-rotations (signed permutation times a
    // small perturbation), the rest raw noise.
    function automatic t_mat random_matrix();
        t_mat m;
        int perm [3];
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            for (int i = 0; i < 9; i++) m[i] = $urandom;
            return m;
        end
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
            int j;
            int t;
            j = $urandom_range(0, i);
            t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        for (int i = 0; i < 9; i++) begin
            logic signed [W-1:0] base;
            base = (perm[i/3] == i % 3) ? (($urandom & 1) ? -ONE_Q : ONE_Q) : '0;
            if (pick < 6) m[i] = base + W'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
            else m[i] = base + W'($signed($urandom_range(0, 2047)) - 1024);
        end
        return m;
    endfunction

    // Directed rows: identity, the four branches, ties, extremes.
    localparam int N_DIRECTED = 14;
    t_mat  dir_mat   [N_DIRECTED];
    t_quat dir_known [N_DIRECTED];
    bit    dir_has   [N_DIRECTED];

    initial begin
        t_mat m;
        t_quat want;
        errors = 0; quats_seen = 0; degen_hits = 0; calm = 0;
        branch_hits = '{default: 0};
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        dir_has = '{default: 0};

        // Identity: w = 1.0, branch trace.
        dir_mat[0] = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};
        dir_known[0] = '{degenerate: 1'b0, branch: rmq_pkg::BR_TRACE, qz: '0, qy: '0,
                         qx: '0, qw: ONE_Q};
        dir_has[0] = 1;
        // 180 degrees about x, y and z: the three diagonal branches.
        dir_mat[1] = '{ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q};
        dir_known[1] = '{degenerate: 1'b0, branch: rmq_pkg::BR_M11, qz: '0, qy: '0,
                         qx: ONE_Q, qw: '0};
        dir_has[1] = 1;
        dir_mat[2] = '{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q};
        dir_mat[3] = '{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q};
        // Zero matrix: trace zero, all ties, falls to m33.
        dir_mat[4] = '{default: '0};
        // Ties between m11 and m22 with negative trace.
        dir_mat[5] = '{-ONE_Q/2, 7, 0, 3, -ONE_Q/2, 0, 0, 0, -ONE_Q};
        // All minimum: trace negative, diagonal ties fall to m33.
        dir_mat[6] = '{default: MINV};
        // All maximum: trace positive, large off-diagonal differences zero.
        dir_mat[7] = '{default: MAXV};
        // Saturating off-diagonals on the m33 branch.
        dir_mat[8] = '{-ONE_Q, MINV, MAXV, MAXV, -ONE_Q, MINV, MINV, MAXV, -ONE_Q + 1};
        // Diagonal 0, 1/2, 1/2 after the overrides: positive trace, trace branch.
        dir_mat[9] = '{0, 5, 5, 5, -ONE_Q/2, 5, 5, 5, -ONE_Q/2 + 0} ;
        dir_mat[9][4] = ONE_Q/2; dir_mat[9][8] = ONE_Q/2; dir_mat[9][0] = 0;
        // Rotation of 90 degrees about z.
        dir_mat[10] = '{0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q};
        // Alternating bit patterns to toggle every data bit.
        dir_mat[11] = '{default: 32'h5555_5555};
        dir_mat[12] = '{default: 32'hAAAA_AAAA};
        dir_mat[13] = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (dir_has[i]) begin
                want = quat_from_matrix(dir_mat[i]);
                if (want !== dir_known[i]) begin
                    $display("%0t: row %0d expected %h actual predictor %h",
                             $time, i, dir_known[i], want);
                    errors++;
                end
            end
            send_matrix(dir_mat[i]);
        end

        // Hold the sender until the pipe has fully drained once.
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 150) calm = 1;
            m = random_matrix();
            send_matrix(m);
        end
        i_s_tvalid <= 1'b0;
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Converted %0d matrices; branches trace/m11/m22/m33 = %0d/%0d/%0d/%0d,",
                 quats_seen, branch_hits[0], branch_hits[1], branch_hits[2],
                 branch_hits[3]);
        $display("degenerate radicands %0d, with stalls on both sides.", degen_hits);
        if (errors == 0 && pending_quats.size() == 0) begin
            $display("PASS rotation_matrix_to_quaternion_unit");
        end else begin
            $display("FAIL rotation_matrix_to_quaternion_unit");
        end
        $finish;
    end

endmodule
